>>> hw/rtl/sida_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
package sida_pkg;

	localparam int VALUE_W    = 32;
	localparam int NUM_DIGITS = 10;
	localparam int DIGIT_W    = 4;
	localparam int CHAR_W     = 6;
	localparam int LEN_W      = 4;
	localparam int CNT_W      = $clog2(VALUE_W);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} sida_state_t;

	// Commands broadcast to every digit cell.
	typedef struct packed {
		logic clear;
		logic conv;
		logic shift_up;
	} cell_ctrl_t;

endpackage

>>> hw/rtl/sida_cell.sv
// One BCD digit cell of the double-dabble chain, also a stage of the output shift line.
module sida_cell (
	input  logic                          clk,
	input  sida_pkg::cell_ctrl_t          ctrl,
	input  logic                          carry_in,
	input  logic [sida_pkg::DIGIT_W-1:0]  digit_in,
	output logic                          carry_out,
	output logic [sida_pkg::DIGIT_W-1:0]  digit
);
	import sida_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// Add three when the digit would reach ten after doubling.
	always_comb begin
		adj = (digit_q >= DIGIT_W'(5)) ? digit_q + DIGIT_W'(3) : digit_q;
	end

	assign carry_out = adj[DIGIT_W-1];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.conv) begin
			digit_q <= {adj[DIGIT_W-2:0], carry_in};
		end else if (ctrl.shift_up) begin
			digit_q <= digit_in;
		end
	end

endmodule

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character per output word, most
// significant first, with a leading '-' for negative values and no leading zeros.
// After a word is taken the magnitude is shifted into a row of ten BCD digit cells
// one bit per cycle, a sizing state counts the significant digits, leading zero
// digits are shifted out of the top cell, then one character leaves per cycle while
// the output is not stalled, and the idle state takes the next word. A new word is
// taken only after the last character of the previous text has been loaded into the
// output register.
module signed_int_to_decimal_ascii (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [sida_pkg::VALUE_W-1:0] value,
	input  logic                                value_valid,
	output logic                                value_stall,
	output logic [sida_pkg::CHAR_W-1:0]         character,
	output logic                                is_last,
	output logic [sida_pkg::LEN_W-1:0]          text_length,
	output logic                                char_valid,
	input  logic                                char_stall
);
	import sida_pkg::*;

	sida_state_t state_q, state_d;

	logic [VALUE_W-1:0] mag_q;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   left_q;
	logic [LEN_W-1:0]   skip_q;

	logic               out_valid_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_last_q;
	logic [LEN_W-1:0]   out_len_q;

	cell_ctrl_t         ctrl;
	logic [DIGIT_W-1:0] digit [NUM_DIGITS];
	logic               carry [NUM_DIGITS];

	logic               in_take;
	logic               out_free;
	logic               out_load;
	logic [CHAR_W-1:0]  out_char_d;
	logic               out_last_d;
	logic [LEN_W-1:0]   ndig;
	logic [VALUE_W-1:0] raw;

	assign raw      = value;
	assign out_free = !out_valid_q || !char_stall;
	assign in_take  = value_valid && !value_stall;

	// Digit cell row: carries run upward during conversion, digits move upward on skip and emit.
	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		sida_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.carry_in  ((i == 0) ? mag_q[VALUE_W-1] : carry[(i == 0) ? 0 : i-1]),
			.digit_in  ((i == 0) ? DIGIT_W'(0) : digit[(i == 0) ? 0 : i-1]),
			.carry_out (carry[i]),
			.digit     (digit[i])
		);
	end

	// Count significant digits: one more than the highest nonzero cell, at least one.
	always_comb begin
		ndig = LEN_W'(1);
		for (int i = 1; i < NUM_DIGITS; i++) begin
			if (digit[i] != '0) begin
				ndig = LEN_W'(i + 1);
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (value_valid) state_d = ST_CONV;
			end
			ST_CONV: begin
				if (cnt_q == CNT_W'(VALUE_W - 1)) state_d = ST_SIZE;
			end
			ST_SIZE: begin
				state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (skip_q == '0) state_d = neg_q ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (out_free) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free && left_q == LEN_W'(1)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		value_stall = 1'b1;
		ctrl        = '0;
		out_load    = 1'b0;
		out_char_d  = CHAR_ZERO + CHAR_W'(digit[NUM_DIGITS-1]);
		out_last_d  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				value_stall = 1'b0;
				ctrl.clear  = 1'b1;
			end
			ST_CONV: begin
				ctrl.conv = 1'b1;
			end
			ST_SIZE: begin
			end
			ST_SKIP: begin
				ctrl.shift_up = (skip_q != '0);
			end
			ST_SIGN: begin
				out_load   = out_free;
				out_char_d = CHAR_MINUS;
			end
			ST_EMIT: begin
				out_load      = out_free;
				out_last_d    = (left_q == LEN_W'(1));
				ctrl.shift_up = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!char_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			mag_q <= raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
			neg_q <= raw[VALUE_W-1];
			cnt_q <= '0;
		end else if (state_q == ST_CONV) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (state_q == ST_SIZE) begin
			len_q  <= ndig + LEN_W'(neg_q);
			left_q <= ndig;
			skip_q <= LEN_W'(NUM_DIGITS) - ndig;
		end else if (state_q == ST_SKIP && skip_q != '0) begin
			skip_q <= skip_q - LEN_W'(1);
		end else if (state_q == ST_EMIT && out_free) begin
			left_q <= left_q - LEN_W'(1);
		end
		if (out_load) begin
			out_char_q <= out_char_d;
			out_last_q <= out_last_d;
			out_len_q  <= len_q;
		end
	end

	assign char_valid  = out_valid_q;
	assign character   = out_char_q;
	assign is_last     = out_last_q;
	assign text_length = out_len_q;

	// The magnitude never overflows the top digit cell.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.conv |-> !carry[NUM_DIGITS-1])
		else $error("carry out of top digit cell");

	// Only digits that remain are emitted.
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (left_q != '0))
		else $error("emit with no digit left");

	// Skipped cells hold leading zeros only.
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP && skip_q != '0) |-> (digit[NUM_DIGITS-1] == '0))
		else $error("nonzero digit dropped");

	// The final character returns the controller to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last_d) |=> (state_q == ST_IDLE))
		else $error("last character without return to idle");

	// The sign is emitted only for negative values.
	a_sign_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) |-> neg_q)
		else $error("sign state on nonnegative value");

endmodule

>>> verif/tb_signed_int_to_decimal_ascii.sv
// Testbench for the signed integer to decimal ASCII text converter.
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii;
	import sida_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic [LEN_W-1:0]  len;
	} text_char_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic signed [VALUE_W-1:0] value = '0;
	logic                      value_valid = 1'b0;
	logic                      value_stall;
	logic [CHAR_W-1:0]         character;
	logic                      is_last;
	logic [LEN_W-1:0]          text_length;
	logic                      char_valid;
	logic                      char_stall = 1'b0;

	text_char_t pending_chars[$];
	int         err_count = 0;
	int         cycle_count = 0;
	int         src_idle_pct = 0;
	int         sink_stall_pct = 0;

	signed_int_to_decimal_ascii u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.character   (character),
		.is_last     (is_last),
		.text_length (text_length),
		.char_valid  (char_valid),
		.char_stall  (char_stall)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Expected text of one value, most significant character first.
	task automatic queue_text(input logic [VALUE_W-1:0] raw);
		logic               neg;
		logic [VALUE_W-1:0] mag;
		logic [3:0]         dig[NUM_DIGITS];
		logic [CHAR_W-1:0]  ch;
		int                 nd;
		int                 total;
		neg = raw[VALUE_W-1];
		// two's complement negation wraps to the right magnitude for the most negative value
		mag = neg ? -raw : raw;
		nd = 0;
		do begin
			dig[nd] = 4'(mag % 10);
			mag = mag / 10;
			nd++;
		end while (mag != 0);
		total = nd + (neg ? 1 : 0);
		if (neg)
			pending_chars.push_back(text_char_t'{CHAR_MINUS, 1'b0, LEN_W'(total)});
		for (int i = nd - 1; i >= 0; i--) begin
			ch = CHAR_ZERO + CHAR_W'(dig[i]);
			pending_chars.push_back(text_char_t'{ch, i == 0, LEN_W'(total)});
		end
	endtask

	task automatic send_value(input logic [VALUE_W-1:0] raw);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			value_valid <= 1'b0;
			@(posedge clk);
		end
		value       <= raw;
		value_valid <= 1'b1;
		do @(posedge clk); while (value_stall);
		queue_text(raw);
	endtask

	// Check each character word taken at the edge, then pick the next stall.
	always @(posedge clk) begin
		text_char_t exp_c;
		if (arst_n && char_valid && !char_stall) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected word char=%0d last=%0d len=%0d", $time,
					character, is_last, text_length);
				err_count++;
			end else begin
				exp_c = pending_chars.pop_front();
				if (character !== exp_c.ch) begin
					$display("%0t: character expected %0d got %0d", $time, exp_c.ch, character);
					err_count++;
				end
				if (is_last !== exp_c.last) begin
					$display("%0t: is_last expected %0d got %0d", $time, exp_c.last, is_last);
					err_count++;
				end
				if (text_length !== exp_c.len) begin
					$display("%0t: text_length expected %0d got %0d", $time, exp_c.len,
						text_length);
					err_count++;
				end
			end
		end
		char_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	task automatic test_extremes();
		send_value(32'sd0);
		send_value(32'sd1);
		send_value(-32'sd1);
		send_value(32'sd2147483647);
		send_value(32'h8000_0000);
		send_value(-32'sd2147483647);
		send_value(32'sd9);
		send_value(-32'sd9);
	endtask

	task automatic test_decade_edges();
		int decade_vals[14] = '{10, 99, 100, -999, 1000, 99999, -100000, 1000000,
			-9999999, 10000000, 999999999, 1000000000, -1000000000, -99};
		foreach (decade_vals[i])
			send_value(decade_vals[i]);
	endtask

	task automatic test_random_values(input int count, input int src_pct, input int sink_pct);
		logic [VALUE_W-1:0] raw;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		repeat (count) begin
			// spread the text lengths: full range, short positive, short negative, near zero
			case ($urandom_range(0, 3))
				0:       raw = $urandom;
				1:       raw = $urandom >> $urandom_range(0, 31);
				2:       raw = -($urandom >> $urandom_range(0, 31));
				default: raw = $urandom_range(0, 20) - 10;
			endcase
			send_value(raw);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_idle_pct   = 36;
		sink_stall_pct = 60;
		test_extremes();
		test_decade_edges();
		test_random_values(160, 36, 60);
		test_random_values(160, 60, 36);
		test_random_values(160, 0, 0);
		value_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
